// ===== hw/rtl/expsrch_pkg.sv =====
// ----------------------------------------------------------------------------
// expsrch_pkg
// shared constants, codes and types of the exponential search block
// ----------------------------------------------------------------------------
package expsrch_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK0,
    ST_DBL,
    ST_BSET,
    ST_BCHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                   found;
    logic [ADDR_W-1:0]      position;
  } result_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

endpackage

// ===== hw/rtl/expsrch_in_if.sv =====
// ----------------------------------------------------------------------------
// expsrch_in_if
// input item channel: load or search request
// ----------------------------------------------------------------------------
interface expsrch_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     mode;
  logic [expsrch_pkg::ADDR_W-1:0]           slot;
  logic signed [expsrch_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, mode, slot, value, input ready);
  modport sink   (input valid, mode, slot, value, output ready);
endinterface

// ===== hw/rtl/expsrch_out_if.sv =====
// ----------------------------------------------------------------------------
// expsrch_out_if
// result item channel: search outcome
// ----------------------------------------------------------------------------
interface expsrch_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [expsrch_pkg::ADDR_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

// ===== hw/rtl/expsrch_cfg_if.sv =====
// ----------------------------------------------------------------------------
// expsrch_cfg_if
// configuration write channel for the entry count register
// ----------------------------------------------------------------------------
interface expsrch_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [expsrch_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

// ===== hw/rtl/expsrch_ram.sv =====
// ----------------------------------------------------------------------------
// expsrch_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module expsrch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/expsrch_ctrl.sv =====
// ----------------------------------------------------------------------------
// expsrch_ctrl
// search sequencer: doubling probe then binary search over the table ram
// ----------------------------------------------------------------------------
module expsrch_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  expsrch_in_if.sink                          in_ch,
  expsrch_out_if.source                       out_ch,
  input  logic [expsrch_pkg::CNT_W-1:0]       entry_count,
  output expsrch_pkg::mem_req_t               mem_req,
  input  logic [expsrch_pkg::VALUE_WIDTH-1:0] ram_rdata
);

  localparam int AW = expsrch_pkg::ADDR_W;
  localparam int CW = expsrch_pkg::CNT_W;
  localparam int VW = expsrch_pkg::VALUE_WIDTH;

  expsrch_pkg::state_t  state_r, state_nxt;
  expsrch_pkg::result_t res_r, res_nxt;
  expsrch_pkg::result_t out_res_r, out_res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [VW-1:0] key_r, key_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        probe_r, probe_nxt;
  logic [AW-1:0]        lo_r, lo_nxt;
  logic [AW-1:0]        hi_r, hi_nxt;
  logic [AW-1:0]        mid_r, mid_nxt;

  logic                 in_fire;
  logic                 is_search;
  logic                 emit_ok;
  logic [CW-1:0]        cnt_sat;
  logic                 rd_eq, rd_lt, rd_le;
  logic [CW-1:0]        nm1_w;
  logic [AW-1:0]        nm1;
  logic [CW-1:0]        probe_dbl;
  logic                 dbl_in_range;
  logic [AW-1:0]        sel_lo, sel_hi, sel_mid;
  logic                 b_end;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign is_search = (in_ch.mode == expsrch_pkg::MODE_SEARCH);
  assign emit_ok   = !out_valid_r || out_ch.ready;
  assign cnt_sat   = (entry_count > CW'(expsrch_pkg::TABLE_DEPTH)) ?
                     CW'(expsrch_pkg::TABLE_DEPTH) : entry_count;

  assign rd_eq = ($signed(ram_rdata) == key_r);
  assign rd_lt = ($signed(ram_rdata) <  key_r);
  assign rd_le = rd_eq || rd_lt;

  assign nm1_w        = n_r - CW'(1);
  assign nm1          = nm1_w[AW-1:0];
  assign probe_dbl    = {probe_r[CW-2:0], 1'b0};
  assign dbl_in_range = (probe_dbl < n_r);

  // range of the next binary step
  always_comb begin
    if (state_r == expsrch_pkg::ST_BSET) begin
      sel_lo = probe_r[AW:1];
      sel_hi = (probe_r < nm1_w) ? probe_r[AW-1:0] : nm1;
    end else if (rd_lt) begin
      sel_lo = mid_r + AW'(1);
      sel_hi = hi_r;
    end else begin
      sel_lo = lo_r;
      sel_hi = mid_r - AW'(1);
    end
    sel_mid = sel_lo + ((sel_hi - sel_lo) >> 1);
  end

  assign b_end = rd_lt ? (mid_r == hi_r) : (mid_r == lo_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      expsrch_pkg::ST_IDLE: begin
        if (in_fire && is_search) begin
          state_nxt = (cnt_sat == '0) ? expsrch_pkg::ST_EMIT : expsrch_pkg::ST_CHK0;
        end
      end
      expsrch_pkg::ST_CHK0: begin
        if (rd_eq) begin
          state_nxt = expsrch_pkg::ST_EMIT;
        end else if (n_r > CW'(1)) begin
          state_nxt = expsrch_pkg::ST_DBL;
        end else begin
          state_nxt = expsrch_pkg::ST_BSET;
        end
      end
      expsrch_pkg::ST_DBL: begin
        if (!rd_le || !dbl_in_range) begin
          state_nxt = expsrch_pkg::ST_BSET;
        end
      end
      expsrch_pkg::ST_BSET: begin
        state_nxt = expsrch_pkg::ST_BCHK;
      end
      expsrch_pkg::ST_BCHK: begin
        if (rd_eq || b_end) begin
          state_nxt = expsrch_pkg::ST_EMIT;
        end
      end
      expsrch_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_nxt = expsrch_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = expsrch_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready   = (state_r == expsrch_pkg::ST_IDLE);
    mem_req.we    = in_fire && !is_search;
    mem_req.waddr = in_ch.slot;
    mem_req.wdata = in_ch.value;
    mem_req.raddr = '0;
    case (state_r)
      expsrch_pkg::ST_CHK0: mem_req.raddr = AW'(1);
      expsrch_pkg::ST_DBL:  mem_req.raddr = probe_dbl[AW-1:0];
      expsrch_pkg::ST_BSET: mem_req.raddr = sel_mid;
      expsrch_pkg::ST_BCHK: mem_req.raddr = sel_mid;
      default:              mem_req.raddr = '0;
    endcase
    out_ch.valid    = out_valid_r;
    out_ch.found    = out_res_r.found;
    out_ch.position = out_res_r.position;
  end

  // datapath
  always_comb begin
    key_nxt       = key_r;
    n_nxt         = n_r;
    probe_nxt     = probe_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      expsrch_pkg::ST_IDLE: begin
        if (in_fire && is_search) begin
          key_nxt = in_ch.value;
          n_nxt   = cnt_sat;
          res_nxt = '0;
        end
      end
      expsrch_pkg::ST_CHK0: begin
        probe_nxt = CW'(1);
        if (rd_eq) begin
          res_nxt.found    = 1'b1;
          res_nxt.position = '0;
        end
      end
      expsrch_pkg::ST_DBL: begin
        if (rd_le) begin
          probe_nxt = probe_dbl;
        end
      end
      expsrch_pkg::ST_BSET: begin
        lo_nxt  = sel_lo;
        hi_nxt  = sel_hi;
        mid_nxt = sel_mid;
      end
      expsrch_pkg::ST_BCHK: begin
        if (rd_eq) begin
          res_nxt.found    = 1'b1;
          res_nxt.position = mid_r;
        end else if (!b_end) begin
          lo_nxt  = sel_lo;
          hi_nxt  = sel_hi;
          mid_nxt = sel_mid;
        end
      end
      expsrch_pkg::ST_EMIT: begin
        if (emit_ok) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= expsrch_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    n_r       <= n_nxt;
    probe_r   <= probe_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

// ===== hw/rtl/exponential_search_sorted_table_top.sv =====
// ----------------------------------------------------------------------------
// exponential_search_sorted_table_top
// sorted table in ram with exponential search, one result per search item
// ----------------------------------------------------------------------------
//  channel  dir  payload               note
//  in_ch    in   mode, slot, value     load writes a slot, search looks up
//  out_ch   out  found, position       one item per search
//  cfg_ch   in   entry_count           always ready, write only when idle
//
//  a load writes its slot as it is accepted; the block stays ready
//  a search holds the input off through chk0, dbl (d doubling reads),
//  bset, bchk (b binary reads), each one ram read per cycle, and emit,
//  which waits on a stalled result; the result is valid as ready returns
//  a finished result waits in the output register; loads go on meanwhile
//  reset clears control only; table entries are undefined until loaded
// ----------------------------------------------------------------------------
module exponential_search_sorted_table_top (
  input logic           clk,
  input logic           rst_n,
  expsrch_in_if.sink    in_ch,
  expsrch_out_if.source out_ch,
  expsrch_cfg_if.sink   cfg_ch
);

  logic [expsrch_pkg::CNT_W-1:0]       entry_count_r, entry_count_nxt;
  expsrch_pkg::mem_req_t               mem_req;
  logic [expsrch_pkg::VALUE_WIDTH-1:0] ram_rdata;

  assign cfg_ch.ready    = 1'b1;
  assign entry_count_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.entry_count : entry_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  expsrch_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .entry_count (entry_count_r),
    .mem_req     (mem_req),
    .ram_rdata   (ram_rdata)
  );

  expsrch_ram #(
    .WIDTH (expsrch_pkg::VALUE_WIDTH),
    .DEPTH (expsrch_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== hw/rtl/expsrch_checker.sv =====
// ----------------------------------------------------------------------------
// expsrch_checker
// port level checks of the exponential search block
// ----------------------------------------------------------------------------
module expsrch_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_mode,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_found,
  input logic [expsrch_pkg::ADDR_W-1:0] out_position
);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // a search item leaves the block busy right after it is accepted
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_mode == expsrch_pkg::MODE_SEARCH) |=> !in_ready)
    else $error("input ready right after a search item");

  // a load item leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_mode == expsrch_pkg::MODE_LOAD) |=> in_ready)
    else $error("block not ready after a load item");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_position == '0))
    else $error("nonzero position on a miss");

  // a new result shows up together with the block going idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while search still running");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_position))
    else $error("result changed while stalled");

endmodule

bind exponential_search_sorted_table_top expsrch_checker u_expsrch_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_mode      (in_ch.mode),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_found    (out_ch.found),
  .out_position (out_ch.position)
);
